>>> design/sle_pkg.sv
// Shared package for the sequential list engine.
// Holds operation codes, the cell command type and default sizing.
// No dependencies.
package sle_pkg;

  localparam int unsigned CAPACITY_DEF = 128;

  // Operation selector codes (tuser on the request channel)
  localparam logic [2:0] FN_GET    = 3'd0;
  localparam logic [2:0] FN_LOCATE = 3'd1;
  localparam logic [2:0] FN_PRIOR  = 3'd2;
  localparam logic [2:0] FN_NEXT   = 3'd3;
  localparam logic [2:0] FN_INSERT = 3'd4;
  localparam logic [2:0] FN_DELETE = 3'd5;
  localparam logic [2:0] FN_CLEAR  = 3'd6;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  // Broadcast command to every cell of the chain
  typedef struct packed {
    cell_op_e   op;
    logic [7:0] pos_idx;  // 0-based position
    logic [7:0] value;
  } sle_cmd_t;

endpackage

>>> design/sle_cell.sv
// One list cell: holds a single element and trades it with its neighbors.
// Depends on sle_pkg for the command type.
module sle_cell import sle_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned IDX      = 0
) (
  input  logic       clk_i,
  input  sle_cmd_t   cmd_i,
  input  logic [7:0] lower_i,  // element of cell IDX-1
  input  logic [7:0] upper_i,  // element of cell IDX+1 (cell 0 for the last cell)
  output logic [7:0] data_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = (IW > 8) ? IW : 8;

  logic [7:0]    data_q, data_d;
  logic [CW-1:0] idx_v, pos_v;

  assign idx_v = CW'(IDX);
  assign pos_v = CW'(cmd_i.pos_idx);

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (idx_v == pos_v) begin
          data_d = cmd_i.value;
        end else if (idx_v > pos_v) begin
          data_d = lower_i;
        end
      end
      CELL_DELETE: begin
        if (idx_v >= pos_v) begin
          data_d = upper_i;
        end
      end
      CELL_ROTATE: data_d = upper_i;
      default:     data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> design/sle_ctrl.sv
// Sequencer for the list engine: handshakes, length, ring walk and result.
// Depends on sle_pkg; drives the cell chain through a broadcast command.
module sle_ctrl import sle_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,
  input  logic [7:0]  head_i,
  output sle_cmd_t    cmd_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = IW + 1;
  localparam int unsigned PW = (KW > 9) ? KW : 9;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [2:0]    func_q;
  logic [7:0]    pos_q, val_q;
  logic [LW-1:0] len_q, len_d;
  logic [IW-1:0] k_q, hit_idx_q;
  logic          hit_q, arm_q, prior_ok_q, next_ok_q, err_q;
  logic [7:0]    prev_q, prior_q, next_q, get_q;
  logic          out_valid_q, out_status_q;
  logic [7:0]    out_data_q, out_found_q, out_count_q;

  logic          accept, load_out, in_list, get_hit, pos_ok, ins_ok;
  logic          res_status;
  logic [7:0]    res_data, res_found;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  assign s_axis_tready = (state_q == ST_IDLE);

  // Range checks on the 1-based position
  assign pos_ok = (pos_q != 8'd0) && (PW'(pos_q) <= PW'(len_q));
  assign ins_ok = (pos_q != 8'd0) && (PW'(pos_q) <= PW'(len_q) + PW'(1))
                  && (len_q < LW'(CAPACITY));

  // Walk step: the head cell holds element k_q
  assign in_list = KW'(k_q) < KW'(len_q);
  assign get_hit = (PW'(k_q) + PW'(1)) == PW'(pos_q);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cmd_o.op      = CELL_HOLD;
    cmd_o.pos_idx = pos_q - 8'd1;
    cmd_o.value   = val_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (func_q)
          FN_GET: begin
            if (pos_ok) begin
              state_d = ST_SCAN;
            end
          end
          FN_LOCATE, FN_PRIOR, FN_NEXT: state_d = ST_SCAN;
          FN_INSERT: begin
            if (ins_ok) begin
              cmd_o.op = CELL_INSERT;
              len_d    = len_q + LW'(1);
            end
          end
          FN_DELETE: begin
            if (pos_ok) begin
              cmd_o.op = CELL_DELETE;
              len_d    = len_q - LW'(1);
            end
          end
          FN_CLEAR: len_d = '0;
          default:  len_d = len_q;
        endcase
      end
      ST_SCAN: begin
        cmd_o.op = CELL_ROTATE;
        if (k_q == IW'(CAPACITY - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Error for every non-walk request is decided in EXEC
  logic err_d;
  always_comb begin
    case (func_q)
      FN_GET, FN_DELETE: err_d = !pos_ok;
      FN_INSERT:         err_d = !ins_ok;
      FN_CLEAR:          err_d = 1'b0;
      default:           err_d = 1'b1;
    endcase
  end

  always_comb begin
    res_status = STATUS_OK;
    res_data   = 8'd0;
    res_found  = 8'd0;
    case (func_q)
      FN_GET: begin
        res_status = err_q;
        res_data   = err_q ? 8'd0 : get_q;
      end
      FN_LOCATE: begin
        res_status = !hit_q;
        res_found  = hit_q ? 8'(32'(hit_idx_q) + 32'd1) : 8'd0;
      end
      FN_PRIOR: begin
        res_status = !prior_ok_q;
        res_data   = prior_ok_q ? prior_q : 8'd0;
      end
      FN_NEXT: begin
        res_status = !next_ok_q;
        res_data   = next_ok_q ? next_q : 8'd0;
      end
      default: res_status = err_q;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      k_q         <= '0;
      hit_q       <= 1'b0;
      arm_q       <= 1'b0;
      prior_ok_q  <= 1'b0;
      next_ok_q   <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      if (state_q == ST_EXEC) begin
        k_q        <= '0;
        hit_q      <= 1'b0;
        arm_q      <= 1'b0;
        prior_ok_q <= 1'b0;
        next_ok_q  <= 1'b0;
        err_q      <= err_d;
      end
      if (state_q == ST_SCAN) begin
        k_q <= k_q + IW'(1);
        if (in_list) begin
          if (!hit_q && head_i == val_q) begin
            hit_q <= 1'b1;
            arm_q <= 1'b1;
            if (k_q != '0) begin
              prior_ok_q <= 1'b1;
            end
          end
          if (arm_q) begin
            next_ok_q <= 1'b1;
            arm_q     <= 1'b0;
          end
        end else begin
          arm_q <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= s_axis_tuser;
      pos_q  <= s_axis_tdata[7:0];
      val_q  <= s_axis_tdata[15:8];
    end
    if (state_q == ST_SCAN) begin
      prev_q <= head_i;
      if (in_list) begin
        if (!hit_q && head_i == val_q) begin
          hit_idx_q <= k_q;
          prior_q   <= prev_q;
        end
        if (arm_q) begin
          next_q <= head_i;
        end
        if (get_hit) begin
          get_q <= head_i;
        end
      end
    end
    if (load_out) begin
      out_status_q <= res_status;
      out_data_q   <= res_data;
      out_found_q  <= res_found;
      out_count_q  <= 8'(len_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_count_q, out_found_q, out_data_q};

  // Checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(CAPACITY))
    else $error("list length beyond capacity");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted request not executed");

  a_insert_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && cmd_o.op == CELL_INSERT) |=> len_q == $past(len_q) + LW'(1))
    else $error("insert did not grow the list");

  a_delete_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && cmd_o.op == CELL_DELETE) |=> len_q == $past(len_q) - LW'(1))
    else $error("delete did not shrink the list");

  a_rotate_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == CELL_ROTATE) |-> state_q == ST_SCAN)
    else $error("ring rotated outside a walk");

endmodule

>>> design/sequential_list_engine_unit.sv
// Top level of the sequential list engine: a ring of element cells and
// the sequencer that drives it. Depends on sle_pkg, sle_cell and sle_ctrl.
//
//  channel         dir  handshake                       payload
//  s_axis (req)    in   s_axis_tvalid / s_axis_tready   tdata {value, position}, tuser func
//  m_axis (result) out  m_axis_tvalid / m_axis_tready   tdata {count, found_position, data},
//                                                       tuser status
//
// Path: insert, delete, clear, an out-of-range get and an unused selector
// go from EXEC straight to DONE. Get, locate, prior and next walk the ring in
// SCAN: the ring of cells makes one full turn past the head cell, one element
// per cycle, and returns to its order.
// Reset clears the length and the handshake state; cell contents are not reset.
// A result waiting on m_axis does not block the request side: the next
// request is taken and executed and holds only at its own result hand-off.
module sequential_list_engine_unit import sle_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] position, [15:8] value
  input  logic [2:0]  s_axis_tuser,   // [2:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data, [15:8] found_position, [23:16] count
  output logic        m_axis_tuser    // [0] status
);

  sle_cmd_t   cmd;
  logic [7:0] cell_data [CAPACITY];

  // Sequencer: owns the length, walks the ring, forms each result transaction
  sle_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .head_i        (cell_data[0]),
    .cmd_o         (cmd)
  );

  // Ring of cells: cell i holds element i; the last cell wraps to cell 0 so a
  // rotate advances every element one place toward the head.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] lower, upper;

    if (g == 0) begin : g_first
      assign lower = 8'd0;  // nothing shifts into the head on insert
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign upper = cell_data[0];
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end

    sle_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[g])
    );
  end

endmodule

>>> tb/sequential_list_engine_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for sequential_list_engine_unit: drives list requests on s_axis and checks
// every result on m_axis against a scoreboard that mirrors the list contents.
// Depends on sle_pkg and the sequential_list_engine_unit RTL.

// One result transaction, in field order
typedef struct packed {
  logic       status;
  logic [7:0] data;
  logic [7:0] found_position;
  logic [7:0] count;
} list_result_t;

class list_scoreboard;
  bit [7:0]     elems [sle_pkg::CAPACITY_DEF];
  int unsigned  length;
  list_result_t pending_results [$];
  int unsigned  mismatches;
  int unsigned  results_checked;
  int unsigned  peak_length;
  int unsigned  full_refusals;
  int unsigned  op_count [8];

  function new();
    length = 0;
    mismatches = 0;
    results_checked = 0;
    peak_length = 0;
    full_refusals = 0;
    foreach (op_count[i]) op_count[i] = 0;
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  // Index of the first element equal to v, or length when absent
  function int unsigned first_index(bit [7:0] v);
    for (int unsigned i = 0; i < length; i++) begin
      if (elems[i] == v) return i;
    end
    return length;
  endfunction

  // Apply one accepted request to the mirrored list and queue its result
  function void note_request(logic [2:0] fn, logic [7:0] pos, logic [7:0] val);
    list_result_t r;
    int unsigned  m;
    r = '0;
    op_count[fn]++;
    case (fn)
      sle_pkg::FN_GET: begin
        if (pos >= 1 && pos <= length) r.data = elems[pos - 1];
        else r.status = sle_pkg::STATUS_ERR;
      end
      sle_pkg::FN_LOCATE: begin
        m = first_index(val);
        if (m < length) r.found_position = 8'(m + 1);
        else r.status = sle_pkg::STATUS_ERR;
      end
      sle_pkg::FN_PRIOR: begin
        m = first_index(val);
        if (m < length && m >= 1) r.data = elems[m - 1];
        else r.status = sle_pkg::STATUS_ERR;
      end
      sle_pkg::FN_NEXT: begin
        m = first_index(val);
        if (m + 1 < length) r.data = elems[m + 1];
        else r.status = sle_pkg::STATUS_ERR;
      end
      sle_pkg::FN_INSERT: begin
        if (pos < 1 || pos > length + 1 || length >= sle_pkg::CAPACITY_DEF) begin
          r.status = sle_pkg::STATUS_ERR;
          if (length >= sle_pkg::CAPACITY_DEF && pos >= 1 && pos <= length + 1)
            full_refusals++;
        end else begin
          for (int unsigned i = length; i >= pos; i--) elems[i] = elems[i - 1];
          elems[pos - 1] = val;
          length++;
        end
      end
      sle_pkg::FN_DELETE: begin
        if (pos < 1 || pos > length) begin
          r.status = sle_pkg::STATUS_ERR;
        end else begin
          for (int unsigned i = pos - 1; i + 1 < length; i++) elems[i] = elems[i + 1];
          length--;
        end
      end
      sle_pkg::FN_CLEAR: length = 0;
      default: r.status = sle_pkg::STATUS_ERR;
    endcase
    r.count = 8'(length);
    if (length > peak_length) peak_length = length;
    pending_results.push_back(r);
  endfunction

  // Compare one result transaction with the oldest queued expectation
  function void check_result(logic [23:0] tdata, logic tuser);
    list_result_t got;
    list_result_t want;
    got.status         = tuser;
    got.data           = tdata[7:0];
    got.found_position = tdata[15:8];
    got.count          = tdata[23:16];
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result status=%0b data=%02h found=%0d count=%0d",
                 $realtime, got.status, got.data, got.found_position, got.count);
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (got.status !== want.status || got.data !== want.data ||
        got.found_position !== want.found_position || got.count !== want.count) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result %0d mismatch: expected status=%0b data=%02h found=%0d count=%0d",
                 $realtime, results_checked, want.status, want.data, want.found_position,
                 want.count);
        $display("    got status=%0b data=%02h found=%0d count=%0d",
                 got.status, got.data, got.found_position, got.count);
      end
    end
  endfunction
endclass

module sequential_list_engine_unit_tb;
  import sle_pkg::*;

  localparam int unsigned LIST_CAP     = CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 1550;
  // Final stretch of the random part runs with no idling on either side
  localparam int unsigned CALM_ITEMS   = 150;
  // Longest correct silence is one full ring turn plus stalls; allow far more
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = LIST_CAP + 12;
  localparam logic [2:0]  FN_UNUSED    = 3'd7;

  typedef enum logic [1:0] {
    MODE_GROW,
    MODE_MIX,
    MODE_SHRINK
  } traffic_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] position, [15:8] value
  logic [2:0]  s_axis_tuser;   // [2:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] data, [15:8] found_position, [23:16] count
  logic        m_axis_tuser;   // [0] status

  list_scoreboard board;
  bit             idle_enabled;
  int unsigned    sink_stall;
  int unsigned    idle_cycles;
  int unsigned    rand_sent;

  sequential_list_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Result sink: drive tready at the falling edge, stalling in short random bursts
  always @(negedge clk_i) begin
    if (sink_stall == 0 && idle_enabled && $urandom_range(0, 5) == 0)
      sink_stall = $urandom_range(1, 4);
    if (sink_stall != 0) begin
      m_axis_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  // Sample results at the rising edge; track cycles with no transaction at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // Watchdog: end the run if the block stops moving transactions
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("sequential_list_engine_unit_tb NOT OK");
    $finish;
  end

  // Present one request from a falling edge and hold it until the transaction;
  // return at the falling edge after it, with tvalid still high.
  task automatic send_request(input logic [2:0] fn, input logic [7:0] pos,
                              input logic [7:0] val);
    int unsigned gap;
    gap = 0;
    if (idle_enabled && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, pos};
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(fn, pos, val);
    @(negedge clk_i);
  endtask

  // Small pool of values so that searches hit and duplicates appear
  function automatic logic [7:0] pool_value();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h5A;
      3: return 8'hA5;
      4: return 8'h01;
      5: return 8'h80;
      6: return 8'h3C;
      default: return 8'hC3;
    endcase
  endfunction

  // Mostly a valid position in 1..span, sometimes an edge or any byte
  function automatic logic [7:0] pick_position(int unsigned span);
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 8 && span > 0) return 8'($urandom_range(1, span));
    if (k == 8) begin
      case ($urandom_range(0, 2))
        0: return 8'h00;
        1: return 8'(span);
        default: return 8'(span + 1);
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Search key: mostly a value present in the list
  function automatic logic [7:0] search_value();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (board.length > 0 && k < 60) return board.elems[$urandom_range(0, board.length - 1)];
    if (k < 80) return pool_value();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_op(traffic_mode_e mode);
    int unsigned r;
    int unsigned ins_w;
    int unsigned del_w;
    case (mode)
      MODE_GROW: begin ins_w = 55; del_w = 5;  end
      MODE_MIX:  begin ins_w = 25; del_w = 20; end
      default:   begin ins_w = 8;  del_w = 45; end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_w) return FN_INSERT;
    if (r < ins_w + del_w) return FN_DELETE;
    r = $urandom_range(0, 99);
    if (r < 25) return FN_GET;
    if (r < 50) return FN_LOCATE;
    if (r < 70) return FN_PRIOR;
    if (r < 90) return FN_NEXT;
    if (r < 96) return FN_UNUSED;
    return (mode == MODE_SHRINK) ? FN_CLEAR : FN_GET;
  endfunction

  // Fill in the fields an operation cares about; leave the rest random
  task automatic send_op(input logic [2:0] fn);
    logic [7:0] pos;
    logic [7:0] val;
    pos = 8'($urandom_range(0, 255));
    val = 8'($urandom_range(0, 255));
    case (fn)
      FN_GET, FN_DELETE: pos = pick_position(board.length);
      FN_INSERT: begin
        pos = pick_position(board.length + 1);
        if ($urandom_range(0, 1) == 1) val = pool_value();
      end
      FN_LOCATE, FN_PRIOR, FN_NEXT: val = search_value();
      default: ;
    endcase
    idle_enabled = (rand_sent + CALM_ITEMS < RANDOM_ITEMS);
    send_request(fn, pos, val);
    rand_sent++;
  endtask

  // Directed part: edges of each field, every operation, each error case
  task automatic run_directed();
    // empty list: every access and search is refused
    send_request(FN_GET,    8'd0,   8'h00);
    send_request(FN_GET,    8'd1,   8'h00);
    send_request(FN_LOCATE, 8'd0,   8'h5A);
    send_request(FN_PRIOR,  8'd0,   8'h5A);
    send_request(FN_NEXT,   8'd0,   8'h5A);
    send_request(FN_DELETE, 8'd1,   8'h00);
    send_request(FN_INSERT, 8'd0,   8'h11);
    send_request(FN_INSERT, 8'd2,   8'h11);
    // build 5A 00 A5 FF: append, insert at head and in the middle
    send_request(FN_INSERT, 8'd1,   8'h00);
    send_request(FN_INSERT, 8'd2,   8'hFF);
    send_request(FN_INSERT, 8'd1,   8'h5A);
    send_request(FN_INSERT, 8'd3,   8'hA5);
    // reads at both ends and one past the end
    send_request(FN_GET,    8'd1,   8'hFF);
    send_request(FN_GET,    8'd4,   8'h00);
    send_request(FN_GET,    8'd5,   8'h00);
    send_request(FN_LOCATE, 8'hFF,  8'hFF);
    send_request(FN_LOCATE, 8'd0,   8'h11);
    // no predecessor at the head, no successor at the tail
    send_request(FN_PRIOR,  8'd0,   8'h5A);
    send_request(FN_PRIOR,  8'd0,   8'hFF);
    send_request(FN_NEXT,   8'd0,   8'hFF);
    send_request(FN_NEXT,   8'd0,   8'h5A);
    send_request(FN_DELETE, 8'd5,   8'h00);
    send_request(FN_DELETE, 8'd2,   8'h00);
    send_request(FN_UNUSED, 8'hFF,  8'hFF);
    send_request(FN_CLEAR,  8'h00,  8'h00);
  endtask

  // Random part: fill to capacity once, then traffic in segments of varying mood
  task automatic run_random();
    traffic_mode_e mode;
    int unsigned   seg_len;
    // fill until full, then hit the full-list refusal and read a full list
    while (board.length < LIST_CAP) send_op(FN_INSERT);
    repeat (4) send_op(FN_INSERT);
    repeat (6) send_op(pick_op(MODE_MIX) == FN_INSERT ? FN_LOCATE : FN_NEXT);
    while (rand_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: mode = MODE_GROW;
        1: mode = MODE_MIX;
        default: mode = MODE_SHRINK;
      endcase
      seg_len = $urandom_range(30, 90);
      repeat (seg_len) begin
        if (rand_sent < RANDOM_ITEMS) send_op(pick_op(mode));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    idle_enabled  = 1'b1;
    rand_sent     = 0;
    board         = new();

    // hold reset low from the start, release it at a falling edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    idle_enabled = 1'b0;

    // drain outstanding results, then give the block time to show stray ones
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ops: get %0d loc %0d pri %0d nxt %0d ins %0d del %0d clr %0d bad %0d",
             board.op_count[FN_GET], board.op_count[FN_LOCATE], board.op_count[FN_PRIOR],
             board.op_count[FN_NEXT], board.op_count[FN_INSERT], board.op_count[FN_DELETE],
             board.op_count[FN_CLEAR], board.op_count[FN_UNUSED]);
    $display("checked %0d results, longest list %0d, full-list refusals %0d, mismatches %0d",
             board.results_checked, board.peak_length, board.full_refusals, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("sequential_list_engine_unit_tb OK");
    end else begin
      if (board.pending() != 0) $display("%0d results never arrived", board.pending());
      $display("sequential_list_engine_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sle_pkg.sv
design/sle_cell.sv
design/sle_ctrl.sv
design/sequential_list_engine_unit.sv
tb/sequential_list_engine_unit_tb.sv
